// File: hw/rtl/mpeg_ps_header_scanner_unit_macros.svh
// Assertion macros shared by the scanner modules.
`ifndef MPEG_PS_HEADER_SCANNER_UNIT_MACROS_SVH
`define MPEG_PS_HEADER_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MPSH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define MPSH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// File: hw/rtl/mpsh_pkg.sv
// Shared types and constants of the program stream header scanner.
package mpsh_pkg;

    localparam int SYNC_LIMIT_DEFAULT = 20;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // configuration register indexes
    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_EXT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIV2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUD1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AUD2    = 3'd5;

    localparam logic [15:0] CODE_RESET [NUM_REGS] = '{
        16'h01B3, 16'h01B5, 16'h01BD, 16'h01BF, 16'h01C0, 16'h01D0
    };

    // word classes found by the front end
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_SEQ  = 3'd1;
    localparam logic [2:0] KIND_EXT  = 3'd2;
    localparam logic [2:0] KIND_PRIV = 3'd3;
    localparam logic [2:0] KIND_AUD  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ODD    = 2'd1;
    localparam logic [1:0] ST_NO_SEQ = 2'd2;

    localparam logic [1:0] VER_MPEG1 = 2'd1;
    localparam logic [1:0] VER_MPEG2 = 2'd2;

    localparam logic [2:0] AUD_MP1 = 3'd1;
    localparam logic [2:0] AUD_MP2 = 3'd2;
    localparam logic [2:0] AUD_MP3 = 3'd3;
    localparam logic [2:0] AUD_AC3 = 3'd5;
    localparam logic [2:0] AUD_PCM = 3'd7;

    // extension id and private stream subtypes, top nibble of the body byte
    localparam logic [3:0] EXT_ID_SEQ  = 4'h1;
    localparam logic [3:0] SUBTYPE_AC3 = 4'h8;
    localparam logic [3:0] SUBTYPE_PCM = 4'hA;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hE0;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [15:0]          wdata;
    } cfg_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] width;
        logic [11:0] height;
        logic [3:0]  aspect_code;
        logic [3:0]  rate_code;
        logic [17:0] bit_rate;
        logic [1:0]  version;
        logic [2:0]  audio_kind;
    } out_item_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
        logic [2:0] word_kind;
        logic       is_sync;
        logic       sync_hdr;
    } q_item_t;

endpackage

// File: hw/rtl/mpsh_chan_if.sv
// Valid/ready channel carrying one payload per request.
interface mpsh_chan_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/mpsh_front.sv
// Front end: code registers, byte intake and start-code classification.
module mpsh_front
    import mpsh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    mpsh_chan_if.sink cfg,
    mpsh_chan_if.sink bytes,
    output logic    push,
    input  logic    push_ready,
    output q_item_t push_item
);

    logic [15:0] code_reg [NUM_REGS];
    logic [7:0]  word_high_reg;
    logic [15:0] word;
    logic [2:0]  kind;

    assign cfg.ready   = 1'b1;
    assign bytes.ready = push_ready;
    assign push        = bytes.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                code_reg[i] <= CODE_RESET[i];
            end
        end
        else if (cfg.valid && (cfg.payload.reg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            code_reg[cfg.payload.reg_index] <= cfg.payload.wdata;
        end
    end

    // the previous accepted byte is the high half whenever the back end pairs a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_high_reg <= '0;
        end
        else if (bytes.valid && push_ready)
        begin
            word_high_reg <= bytes.payload.data_byte;
        end
    end

    assign word = {word_high_reg, bytes.payload.data_byte};

    always_comb
    begin
        if (word == code_reg[REG_SEQ])
            kind = KIND_SEQ;
        else if (word == code_reg[REG_SEQ_EXT])
            kind = KIND_EXT;
        else if (word == code_reg[REG_PRIV1] || word == code_reg[REG_PRIV2])
            kind = KIND_PRIV;
        else if (word == code_reg[REG_AUD1] || word == code_reg[REG_AUD2])
            kind = KIND_AUD;
        else
            kind = KIND_NONE;
    end

    always_comb
    begin
        push_item.data_byte   = bytes.payload.data_byte;
        push_item.end_of_file = bytes.payload.end_of_file;
        push_item.word_kind   = kind;
        push_item.is_sync     = (bytes.payload.data_byte == SYNC_BYTE);
        push_item.sync_hdr    = ((bytes.payload.data_byte & SYNC_MASK) == SYNC_MASK);
    end

endmodule

// File: hw/rtl/mpsh_queue.sv
// Small FIFO between the classifier and the header state machine.
`include "mpeg_ps_header_scanner_unit_macros.svh"
module mpsh_queue
    import mpsh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  q_item_t wr_item,
    output logic    rd_valid,
    input  logic    rd_ready,
    output q_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        if (do_wr && !do_rd)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_rd && !do_wr)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    `MPSH_ASSERT_IMPL(q_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `MPSH_ASSERT_IMPL(q_empty_ptrs, count_reg == '0, wr_ptr_reg == rd_ptr_reg)
    `MPSH_ASSERT_IMPL(q_full_ptrs, count_reg == CNT_W'(DEPTH), wr_ptr_reg == rd_ptr_reg)

endmodule

// File: hw/rtl/mpsh_back.sv
// Back end: header state machine, summary fields and result register.
`include "mpeg_ps_header_scanner_unit_macros.svh"
module mpsh_back
    import mpsh_pkg::*;
#(
    parameter int SYNC_SEARCH_LIMIT = SYNC_LIMIT_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    output logic    q_ready,
    input  q_item_t q_item,
    mpsh_chan_if.source summary
);

    localparam int SC_W = $clog2(SYNC_SEARCH_LIMIT + 1);

    localparam logic [2:0] PH_WORD  = 3'd0;
    localparam logic [2:0] PH_SEQ   = 3'd1;
    localparam logic [2:0] PH_EXT   = 3'd2;
    localparam logic [2:0] PH_PRIV  = 3'd3;
    localparam logic [2:0] PH_ASKIP = 3'd4;
    localparam logic [2:0] PH_ASRCH = 3'd5;
    localparam logic [2:0] PH_ASYNC = 3'd6;

    logic [2:0]      phase_reg, phase_next;
    logic [2:0]      bc_reg, bc_next;
    logic [31:0]     shift_reg, shift_next;
    logic [SC_W-1:0] sync_count_reg, sync_count_next;
    logic            video_reg, video_next;
    logic            audio_reg, audio_next;
    logic            stopped_reg, stopped_next;
    out_item_t       fields_reg, fields_next;
    logic            out_valid_reg;
    out_item_t       out_item_reg;

    logic            pop;
    logic            stop;
    logic            result;
    logic [1:0]      res_status;
    out_item_t       res_item;
    logic [7:0]      b;
    logic [2:0]      bc_inc;
    logic [SC_W-1:0] sc_inc;
    logic [31:0]     sw_in;

    assign q_ready         = !out_valid_reg || summary.ready;
    assign pop             = q_valid && q_ready;
    assign summary.valid   = out_valid_reg;
    assign summary.payload = out_item_reg;

    assign b      = q_item.data_byte;
    assign bc_inc = 3'(bc_reg + 1'b1);
    assign sc_inc = SC_W'(sync_count_reg + 1'b1);
    assign sw_in  = {shift_reg[23:0], b};

    always_comb
    begin
        phase_next      = phase_reg;
        bc_next         = bc_reg;
        shift_next      = shift_reg;
        sync_count_next = sync_count_reg;
        video_next      = video_reg;
        audio_next      = audio_reg;
        stopped_next    = stopped_reg;
        fields_next     = fields_reg;
        stop            = 1'b0;
        result          = 1'b0;
        res_status      = ST_OK;
        res_item        = '0;

        if (pop && !stopped_reg)
        begin
            unique case (phase_reg)
                PH_WORD:
                begin
                    if (bc_reg == 3'd0)
                    begin
                        bc_next = 3'd1;
                    end
                    else
                    begin
                        bc_next    = 3'd0;
                        shift_next = '0;
                        case (q_item.word_kind)
                            KIND_SEQ:
                            begin
                                if (video_reg)
                                    stop = 1'b1;
                                else
                                    phase_next = PH_SEQ;
                            end
                            KIND_EXT:  phase_next = PH_EXT;
                            KIND_PRIV: phase_next = PH_PRIV;
                            KIND_AUD:
                            begin
                                if (audio_reg)
                                    stop = 1'b1;
                                else
                                    phase_next = PH_ASKIP;
                            end
                            default: ;
                        endcase
                    end
                end
                PH_SEQ:
                begin
                    shift_next = sw_in;
                    bc_next    = bc_inc;
                    if (bc_inc == 3'd4)
                    begin
                        fields_next.width       = sw_in[31:20];
                        fields_next.height      = sw_in[19:8];
                        fields_next.aspect_code = sw_in[7:4];
                        fields_next.rate_code   = sw_in[3:0];
                    end
                    else if (bc_inc == 3'd0)
                    begin
                        fields_next.bit_rate = sw_in[31:14];
                        fields_next.version  = VER_MPEG1;
                        video_next = 1'b1;
                        phase_next = PH_WORD;
                        bc_next    = 3'd0;
                        stop       = audio_reg;
                    end
                end
                PH_EXT:
                begin
                    if (bc_reg == 3'd0 && b[7:4] == EXT_ID_SEQ)
                        fields_next.version = VER_MPEG2;
                    bc_next = bc_inc;
                    if (bc_inc >= 3'd4)
                    begin
                        phase_next = PH_WORD;
                        bc_next    = 3'd0;
                        stop       = video_reg && audio_reg;
                    end
                end
                PH_PRIV:
                begin
                    if (bc_reg < 3'd2)
                    begin
                        bc_next = bc_inc;
                    end
                    else
                    begin
                        if (b[7:4] == SUBTYPE_AC3)
                            fields_next.audio_kind = AUD_AC3;
                        else if (b[7:4] == SUBTYPE_PCM)
                            fields_next.audio_kind = AUD_PCM;
                        phase_next = PH_WORD;
                        bc_next    = 3'd0;
                        stop       = video_reg && audio_reg;
                    end
                end
                PH_ASKIP:
                begin
                    bc_next = bc_inc;
                    if (bc_inc >= 3'd2)
                    begin
                        phase_next      = PH_ASRCH;
                        sync_count_next = '0;
                    end
                end
                PH_ASRCH:
                begin
                    sync_count_next = sc_inc;
                    if (q_item.is_sync)
                    begin
                        phase_next = PH_ASYNC;
                    end
                    else if (sc_inc >= SC_W'(SYNC_SEARCH_LIMIT))
                    begin
                        phase_next = PH_WORD;
                        bc_next    = 3'd0;
                    end
                end
                PH_ASYNC:
                begin
                    if (q_item.sync_hdr)
                    begin
                        // layer code 0 keeps the kind but still counts as audio
                        case (b[2:1])
                            2'd1:    fields_next.audio_kind = AUD_MP3;
                            2'd2:    fields_next.audio_kind = AUD_MP2;
                            2'd3:    fields_next.audio_kind = AUD_MP1;
                            default: ;
                        endcase
                        audio_next = 1'b1;
                        phase_next = PH_WORD;
                        bc_next    = 3'd0;
                        stop       = video_reg;
                    end
                    else if (sync_count_reg >= SC_W'(SYNC_SEARCH_LIMIT))
                    begin
                        phase_next = PH_WORD;
                        bc_next    = 3'd0;
                    end
                    else
                    begin
                        phase_next = PH_ASRCH;
                    end
                end
                default:
                begin
                    phase_next = PH_WORD;
                    bc_next    = 3'd0;
                end
            endcase

            if (stop)
            begin
                result       = 1'b1;
                stopped_next = 1'b1;
                res_status   = (fields_next.version == '0) ? ST_NO_SEQ : ST_OK;
            end
            else if (q_item.end_of_file)
            begin
                result = 1'b1;
                if (phase_next == PH_WORD && bc_next == 3'd1)
                    res_status = ST_ODD;
                else
                    res_status = (fields_next.version == '0) ? ST_NO_SEQ : ST_OK;
            end
        end

        if (res_status == ST_OK)
            res_item = fields_next;
        res_item.status = res_status;

        // end of file starts a new file, stopped or not
        if (pop && q_item.end_of_file)
        begin
            phase_next      = PH_WORD;
            bc_next         = 3'd0;
            shift_next      = '0;
            sync_count_next = '0;
            video_next      = 1'b0;
            audio_next      = 1'b0;
            stopped_next    = 1'b0;
            fields_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WORD;
            bc_reg         <= '0;
            shift_reg      <= '0;
            sync_count_reg <= '0;
            video_reg      <= 1'b0;
            audio_reg      <= 1'b0;
            stopped_reg    <= 1'b0;
            fields_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bc_reg         <= bc_next;
            shift_reg      <= shift_next;
            sync_count_reg <= sync_count_next;
            video_reg      <= video_next;
            audio_reg      <= audio_next;
            stopped_reg    <= stopped_next;
            fields_reg     <= fields_next;
            if (pop && result)
                out_valid_reg <= 1'b1;
            else if (summary.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && result)
            out_item_reg <= res_item;
    end

    `MPSH_ASSERT_IMPL(stopped_silent, pop && stopped_reg, !result)
    `MPSH_ASSERT_IMPL(err_fields_zero, out_valid_reg && out_item_reg.status != ST_OK,
        out_item_reg.version == '0 && out_item_reg.audio_kind == '0 && out_item_reg.width == '0)
    `MPSH_ASSERT_IMPL(sync_count_range, phase_reg == PH_ASRCH,
        sync_count_reg < SC_W'(SYNC_SEARCH_LIMIT))
    `MPSH_ASSERT_NEXT(stop_latched, pop && stop && !q_item.end_of_file, stopped_reg)

endmodule

// File: hw/rtl/mpeg_ps_header_scanner_unit.sv
// Takes one stream byte per cycle while the FIFO has room: the classifier compares
// each byte pair against the six start codes as it is taken, a FIFO (four entries
// by default) parts it from the header state machine, and that machine retires one
// byte per cycle, so sustained rate is one byte every cycle while the summary port
// keeps up. The output register loads a summary at the same clock edge at which
// the state machine takes the byte causing it (end of file, or the stop on a second
// sequence/audio header or once both are found); a held summary stalls the state
// machine, and intake stops once the FIFO fills. Code registers take writes every cycle.
module mpeg_ps_header_scanner_unit
    import mpsh_pkg::*;
#(
    parameter int SYNC_SEARCH_LIMIT = SYNC_LIMIT_DEFAULT,
    parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    mpsh_chan_if.sink   cfg,
    mpsh_chan_if.sink   bytes,
    mpsh_chan_if.source summary
);

    logic    push, push_ready;
    q_item_t push_item;
    logic    q_valid, q_ready;
    q_item_t q_item;

    mpsh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .bytes      (bytes),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    mpsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    mpsh_back #(
        .SYNC_SEARCH_LIMIT (SYNC_SEARCH_LIMIT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .summary (summary)
    );

endmodule
